// ----- design/pca_pkg.sv -----
// Shared types and constants for the conditional anti-windup PID controller.
package pca_pkg;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int DATA_W         = 16;
    localparam int ERR_W          = DATA_W + 1;
    localparam int ACC_W          = 32;
    localparam int PROD_W         = DATA_W + ERR_W;
    localparam int ADDR_W         = 5;
    localparam int APB_W          = 32;

    localparam logic [2:0] REG_GAIN_PROP  = 3'd0;
    localparam logic [2:0] REG_GAIN_INTEG = 3'd1;
    localparam logic [2:0] REG_GAIN_DERIV = 3'd2;
    localparam logic [2:0] REG_DRIVE_LOW  = 3'd3;
    localparam logic [2:0] REG_DRIVE_HIGH = 3'd4;

    localparam logic [DATA_W-1:0] DRIVE_HIGH_RESET = 16'd1999;

    typedef struct packed {
        logic [DATA_W-1:0] gain_prop;
        logic [DATA_W-1:0] gain_integ;
        logic [DATA_W-1:0] gain_deriv;
        logic [DATA_W-1:0] drive_low_limit;
        logic [DATA_W-1:0] drive_high_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        gain_prop:        '0,
        gain_integ:       '0,
        gain_deriv:       '0,
        drive_low_limit:  '0,
        drive_high_limit: DRIVE_HIGH_RESET
    };

    typedef struct packed {
        logic [ACC_W-1:0] p_term;
        logic [ACC_W-1:0] d_term;
        logic [ACC_W-1:0] i_term;
        logic             err_neg;
        logic             err_pos;
    } prod_t;

endpackage

// ----- design/pid_conditional_antiwindup_top.sv -----
// Top level of the PID controller with conditional-integration anti-windup.
//
// Input channel: in_valid / in_stall with target and measured (signed 16 bit).
// A transaction is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with drive (signed 16 bit), one per input.
// Registers over APB: gain_prop, gain_integ, gain_deriv (signed Q8), drive_low_limit
// and drive_high_limit at byte addresses 0, 4, 8, 12, 16; write them while idle.
// Latency: drive shows up two cycles after the edge that takes the input transaction
// (that edge loads the input register, then the product and output registers follow).
// Throughput: one transaction per cycle; the integrator feeds back within the output
// stage, so consecutive samples follow with no gap.
// Reset clears the integrator, the previous measurement and all gains and low limit;
// the high limit resets to 1999.
// When out_stall is high the output holds; earlier stages keep filling until full,
// then in_stall rises.
module pid_conditional_antiwindup_top
#(
    parameter int GAIN_FRAC_BITS = pca_pkg::GAIN_FRAC_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pca_pkg::ADDR_W-1:0]  paddr,
    input  logic [pca_pkg::APB_W-1:0]   pwdata,
    output logic [pca_pkg::APB_W-1:0]   prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [pca_pkg::DATA_W-1:0]  target,
    input  logic [pca_pkg::DATA_W-1:0]  measured,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [pca_pkg::DATA_W-1:0]  drive
);

    pca_pkg::cfg_t  cfg;
    pca_pkg::prod_t prod;
    logic           prod_valid;
    logic           prod_stall;

    pca_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pca_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .target     (target),
        .measured   (measured),
        .prod_valid (prod_valid),
        .prod_stall (prod_stall),
        .prod       (prod)
    );

    pca_back
    #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .prod_valid (prod_valid),
        .prod_stall (prod_stall),
        .prod       (prod),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .drive      (drive)
    );

endmodule

// ----- design/pca_cfg_regs.sv -----
// APB configuration registers: gains and drive limits.
module pca_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pca_pkg::ADDR_W-1:0]  paddr,
    input  logic [pca_pkg::APB_W-1:0]   pwdata,
    output logic [pca_pkg::APB_W-1:0]   prdata,
    output logic                        pready,
    output pca_pkg::cfg_t               cfg
);

    pca_pkg::cfg_t              cfg_reg;
    pca_pkg::cfg_t              cfg_next;
    logic [2:0]                 reg_index;
    logic                       wr_en;
    logic [pca_pkg::DATA_W-1:0] wdata;
    logic [pca_pkg::DATA_W-1:0] rdata;

    assign reg_index = paddr[pca_pkg::ADDR_W-1:2];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign wdata     = pwdata[pca_pkg::DATA_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                pca_pkg::REG_GAIN_PROP:  cfg_next.gain_prop        = wdata;
                pca_pkg::REG_GAIN_INTEG: cfg_next.gain_integ       = wdata;
                pca_pkg::REG_GAIN_DERIV: cfg_next.gain_deriv       = wdata;
                pca_pkg::REG_DRIVE_LOW:  cfg_next.drive_low_limit  = wdata;
                pca_pkg::REG_DRIVE_HIGH: cfg_next.drive_high_limit = wdata;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            pca_pkg::REG_GAIN_PROP:  rdata = cfg_reg.gain_prop;
            pca_pkg::REG_GAIN_INTEG: rdata = cfg_reg.gain_integ;
            pca_pkg::REG_GAIN_DERIV: rdata = cfg_reg.gain_deriv;
            pca_pkg::REG_DRIVE_LOW:  rdata = cfg_reg.drive_low_limit;
            pca_pkg::REG_DRIVE_HIGH: rdata = cfg_reg.drive_high_limit;
            default:                 rdata = '0;
        endcase
    end

    assign prdata = {{(pca_pkg::APB_W-pca_pkg::DATA_W){rdata[pca_pkg::DATA_W-1]}}, rdata};
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= pca_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- design/pca_front.sv -----
// Input register and product stage: error, measurement change and the three gain products.
module pca_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pca_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [pca_pkg::DATA_W-1:0]  target,
    input  logic [pca_pkg::DATA_W-1:0]  measured,
    output logic                        prod_valid,
    input  logic                        prod_stall,
    output pca_pkg::prod_t              prod
);

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [pca_pkg::DATA_W-1:0]  tgt_reg;
    logic [pca_pkg::DATA_W-1:0]  meas_reg;
    logic [pca_pkg::DATA_W-1:0]  prev_reg;
    logic                        s2_valid_reg;
    logic                        s2_valid_next;
    pca_pkg::prod_t              prod_reg;
    pca_pkg::prod_t              prod_next;

    logic                        s2_free;
    logic                        s1_free;
    logic                        s1_move;
    logic                        in_take;
    logic signed [pca_pkg::ERR_W-1:0]  err;
    logic signed [pca_pkg::ERR_W-1:0]  delta;
    logic signed [pca_pkg::PROD_W-1:0] kp_ext;
    logic signed [pca_pkg::PROD_W-1:0] ki_ext;
    logic signed [pca_pkg::PROD_W-1:0] kd_ext;
    logic signed [pca_pkg::PROD_W-1:0] err_ext;
    logic signed [pca_pkg::PROD_W-1:0] delta_ext;
    logic signed [pca_pkg::PROD_W-1:0] p_full;
    logic signed [pca_pkg::PROD_W-1:0] d_full;
    logic signed [pca_pkg::PROD_W-1:0] i_full;

    assign s2_free  = !s2_valid_reg || !prod_stall;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_stall = !s1_free;
    assign in_take  = in_valid && s1_free;

    assign err   = $signed({tgt_reg[pca_pkg::DATA_W-1], tgt_reg})
                 - $signed({meas_reg[pca_pkg::DATA_W-1], meas_reg});
    assign delta = $signed({meas_reg[pca_pkg::DATA_W-1], meas_reg})
                 - $signed({prev_reg[pca_pkg::DATA_W-1], prev_reg});

    assign kp_ext    = {{(pca_pkg::PROD_W-pca_pkg::DATA_W){cfg.gain_prop[pca_pkg::DATA_W-1]}},
                        cfg.gain_prop};
    assign ki_ext    = {{(pca_pkg::PROD_W-pca_pkg::DATA_W){cfg.gain_integ[pca_pkg::DATA_W-1]}},
                        cfg.gain_integ};
    assign kd_ext    = {{(pca_pkg::PROD_W-pca_pkg::DATA_W){cfg.gain_deriv[pca_pkg::DATA_W-1]}},
                        cfg.gain_deriv};
    assign err_ext   = {{(pca_pkg::PROD_W-pca_pkg::ERR_W){err[pca_pkg::ERR_W-1]}}, err};
    assign delta_ext = {{(pca_pkg::PROD_W-pca_pkg::ERR_W){delta[pca_pkg::ERR_W-1]}}, delta};

    assign p_full = kp_ext * err_ext;
    assign d_full = kd_ext * delta_ext;
    assign i_full = ki_ext * err_ext;

    always_comb
    begin
        prod_next.p_term  = p_full[pca_pkg::ACC_W-1:0];
        prod_next.d_term  = d_full[pca_pkg::ACC_W-1:0];
        prod_next.i_term  = i_full[pca_pkg::ACC_W-1:0];
        prod_next.err_neg = err[pca_pkg::ERR_W-1];
        prod_next.err_pos = !err[pca_pkg::ERR_W-1] && (err != '0);
    end

    assign s1_valid_next = s1_free ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_free ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            prev_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (s1_move)
            begin
                prev_reg <= meas_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tgt_reg  <= target;
            meas_reg <= measured;
        end
        if (s1_move)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = s2_valid_reg;
    assign prod       = prod_reg;

endmodule

// ----- design/pca_back.sv -----
// Integrator with conditional update, output scaling, clamp and output register.
module pca_back
#(
    parameter int GAIN_FRAC_BITS = pca_pkg::GAIN_FRAC_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pca_pkg::cfg_t               cfg,
    input  logic                        prod_valid,
    output logic                        prod_stall,
    input  pca_pkg::prod_t              prod,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [pca_pkg::DATA_W-1:0]  drive
);

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [pca_pkg::DATA_W-1:0]  drive_reg;
    logic [pca_pkg::DATA_W-1:0]  drive_next;
    logic [pca_pkg::ACC_W-1:0]   acc_reg;
    logic [pca_pkg::ACC_W-1:0]   acc_next;

    logic                        out_free;
    logic                        take;
    logic [pca_pkg::ACC_W-1:0]   trend;
    logic [pca_pkg::ACC_W-1:0]   hi_ext;
    logic [pca_pkg::ACC_W-1:0]   lo_ext;
    logic [pca_pkg::ACC_W-1:0]   hi_scaled;
    logic [pca_pkg::ACC_W-1:0]   lo_scaled;
    logic                        integrate;
    logic [pca_pkg::ACC_W-1:0]   integ_add;
    logic [pca_pkg::ACC_W-1:0]   sum;
    logic signed [pca_pkg::ACC_W-1:0] res;

    assign out_free   = !out_valid_reg || !out_stall;
    assign prod_stall = !out_free;
    assign take       = prod_valid && out_free;

    assign hi_ext = {{(pca_pkg::ACC_W-pca_pkg::DATA_W){cfg.drive_high_limit[pca_pkg::DATA_W-1]}},
                     cfg.drive_high_limit};
    assign lo_ext = {{(pca_pkg::ACC_W-pca_pkg::DATA_W){cfg.drive_low_limit[pca_pkg::DATA_W-1]}},
                     cfg.drive_low_limit};
    assign hi_scaled = hi_ext << GAIN_FRAC_BITS;
    assign lo_scaled = lo_ext << GAIN_FRAC_BITS;

    assign trend = prod.p_term + acc_reg - prod.d_term;

    assign integrate = ($signed(trend) < $signed(hi_scaled)
                        && $signed(trend) > $signed(lo_scaled))
                    || ($signed(trend) >= $signed(hi_scaled) && prod.err_neg)
                    || ($signed(trend) <= $signed(lo_scaled) && prod.err_pos);

    assign integ_add = integrate ? prod.i_term : '0;
    assign acc_next  = take ? (acc_reg + integ_add) : acc_reg;
    assign sum       = trend + integ_add;
    assign res       = $signed(sum) >>> GAIN_FRAC_BITS;

    always_comb
    begin
        priority if (res > $signed(hi_ext))
        begin
            drive_next = cfg.drive_high_limit;
        end
        else if (res < $signed(lo_ext))
        begin
            drive_next = cfg.drive_low_limit;
        end
        else
        begin
            drive_next = res[pca_pkg::DATA_W-1:0];
        end
    end

    assign out_valid_next = out_free ? prod_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

endmodule

// ----- test/tb_top.sv -----
// Testbench for the anti-windup PID controller: directed table, random phases, predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PHASES      = 10;
    localparam int         PHASE_ITEMS = 95;
    localparam int         HOLD_CYCLES = 120;
    localparam logic [2:0] REG_SPARE   = 3'd5;

    typedef struct {
        int          set;
        logic [15:0] tgt;
        logic [15:0] meas;
        bit          known;
        logic [15:0] drive;
    } plan_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [pca_pkg::ADDR_W-1:0] paddr;
    logic [pca_pkg::APB_W-1:0]  pwdata;
    logic [pca_pkg::APB_W-1:0]  prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_stall;
    logic [pca_pkg::DATA_W-1:0] target;
    logic [pca_pkg::DATA_W-1:0] measured;
    logic                       out_valid;
    logic                       out_stall;
    logic [pca_pkg::DATA_W-1:0] drive;

    logic [15:0]        regs_now [5];
    logic signed [31:0] integ_sum;
    logic [15:0]        last_meas;
    logic [15:0]        drive_q [$];
    int                 errors = 0;
    int                 cycle_count = 0;
    bit                 calm;
    bit                 hold_req;
    bit                 hold_done = 1'b0;
    int                 hold_left = 0;

    string reg_name [5] = '{"gain_prop", "gain_integ", "gain_deriv",
                            "drive_low_limit", "drive_high_limit"};

    // prop, integ, deriv, low limit, high limit
    pca_pkg::cfg_t preset [5] = '{
        '{16'h0000, 16'h0000, 16'h0100, 16'h8000, 16'h7FFF},
        '{16'h0100, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF},
        '{16'h0100, 16'h0000, 16'h0000, 16'h0064, 16'hFF9C},
        '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF},
        '{16'h0000, 16'h0100, 16'h0000, 16'hFFF6, 16'h000A}
    };

    plan_row_t plan [23] = '{
        '{0, 16'd0,     16'd1000,  1'b1, -16'sd1000},
        '{0, 16'd0,     16'd1000,  1'b1, 16'd0},
        '{0, 16'd0,     16'h8000,  1'b1, 16'h7FFF},
        '{0, 16'd0,     16'h7FFF,  1'b1, 16'h8000},
        '{0, 16'd0,     16'h7FFF,  1'b1, 16'd0},
        '{1, 16'd100,   16'd40,    1'b1, 16'd60},
        '{1, 16'h7FFF,  16'h8000,  1'b1, 16'h7FFF},
        '{1, 16'h8000,  16'h7FFF,  1'b1, 16'h8000},
        '{1, 16'hFFFF,  16'd0,     1'b1, 16'hFFFF},
        '{2, 16'd50,    16'd0,     1'b1, -16'sd100},
        '{2, -16'sd200, 16'd0,     1'b1, 16'd100},
        '{2, -16'sd100, 16'd0,     1'b1, 16'd100},
        '{3, 16'h7FFF,  16'h8000,  1'b0, 16'd0},
        '{3, 16'h8000,  16'h7FFF,  1'b0, 16'd0},
        '{3, 16'h7FFF,  16'h8000,  1'b0, 16'd0},
        '{3, 16'd0,     16'd0,     1'b0, 16'd0},
        '{3, 16'hFFFF,  16'hFFFF,  1'b0, 16'd0},
        '{4, 16'd100,   16'd0,     1'b0, 16'd0},
        '{4, 16'd100,   16'd0,     1'b0, 16'd0},
        '{4, 16'd100,   16'd0,     1'b0, 16'd0},
        '{4, -16'sd100, 16'd0,     1'b0, 16'd0},
        '{4, -16'sd100, 16'd0,     1'b0, 16'd0},
        '{4, 16'd0,     16'd0,     1'b0, 16'd0}
    };

    pid_conditional_antiwindup_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .target    (target),
        .measured  (measured),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [15:0] pid_next(input logic [15:0] tgt, input logic [15:0] meas);
        logic signed [31:0] err;
        logic signed [31:0] p_part;
        logic signed [31:0] d_part;
        logic signed [31:0] trend;
        logic signed [31:0] hi_lim;
        logic signed [31:0] lo_lim;
        logic signed [31:0] hi_q8;
        logic signed [31:0] lo_q8;
        logic signed [31:0] res;
        err    = 32'($signed(tgt)) - 32'($signed(meas));
        p_part = 32'($signed(regs_now[pca_pkg::REG_GAIN_PROP])) * err;
        d_part = 32'($signed(regs_now[pca_pkg::REG_GAIN_DERIV]))
               * (32'($signed(meas)) - 32'($signed(last_meas)));
        hi_lim = 32'($signed(regs_now[pca_pkg::REG_DRIVE_HIGH]));
        lo_lim = 32'($signed(regs_now[pca_pkg::REG_DRIVE_LOW]));
        hi_q8  = hi_lim <<< pca_pkg::GAIN_FRAC_BITS;
        lo_q8  = lo_lim <<< pca_pkg::GAIN_FRAC_BITS;
        last_meas = meas;
        trend = p_part + integ_sum - d_part;
        if ((trend < hi_q8 && trend > lo_q8) || (trend >= hi_q8 && err < 0) ||
            (trend <= lo_q8 && err > 0))
            integ_sum = integ_sum + 32'($signed(regs_now[pca_pkg::REG_GAIN_INTEG])) * err;
        res = (p_part + integ_sum - d_part) >>> pca_pkg::GAIN_FRAC_BITS;
        if (res > hi_lim)
            res = hi_lim;
        else if (res < lo_lim)
            res = lo_lim;
        return res[15:0];
    endfunction

    function automatic logic [15:0] pick_gain();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 1024) - 512);
    endfunction

    function automatic pca_pkg::cfg_t pick_cfg();
        pca_pkg::cfg_t c;
        logic [15:0]   a;
        logic [15:0]   b;
        logic [15:0]   swap;
        c.gain_prop  = pick_gain();
        c.gain_integ = pick_gain();
        c.gain_deriv = pick_gain();
        a = 16'($urandom);
        b = 16'($urandom);
        case ($urandom_range(0, 3))
            0:
            begin
                a = 16'h8000;
                b = 16'h7FFF;
            end
            1:
            begin
                if ($signed(a) > $signed(b))
                begin
                    swap = a;
                    a = b;
                    b = swap;
                end
            end
            2:
            begin
                if ($signed(a) < $signed(b))
                begin
                    swap = a;
                    a = b;
                    b = swap;
                end
            end
            default:
            begin
                a = 16'(0 - $urandom_range(0, 3000));
                b = 16'($urandom_range(0, 3000));
            end
        endcase
        c.drive_low_limit  = a;
        c.drive_high_limit = b;
        return c;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{16{val[15]}}, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx <= pca_pkg::REG_DRIVE_HIGH)
            regs_now[idx] = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_read(input logic [2:0] idx, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_cfg(input pca_pkg::cfg_t c);
        reg_write(pca_pkg::REG_GAIN_PROP, c.gain_prop);
        reg_write(pca_pkg::REG_GAIN_INTEG, c.gain_integ);
        reg_write(pca_pkg::REG_GAIN_DERIV, c.gain_deriv);
        reg_write(pca_pkg::REG_DRIVE_LOW, c.drive_low_limit);
        reg_write(pca_pkg::REG_DRIVE_HIGH, c.drive_high_limit);
    endtask

    task automatic send(input logic [15:0] tgt, input logic [15:0] meas,
                        input bit known, input logic [15:0] want);
        logic [15:0] expected;
        in_valid <= 1'b1;
        target   <= tgt;
        measured <= meas;
        do @(posedge clk); while (in_stall);
        expected = pid_next(tgt, meas);
        drive_q.push_back(known ? want : expected);
        if (!calm && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // drop valid and wait for the pipeline to drain
    task automatic settle();
        in_valid <= 1'b0;
        while (drive_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 13);
    end

    always @(posedge clk)
    begin : drive_check
        logic [15:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_q.size() == 0)
            begin
                $error("drive: expected nothing, got %0d", $signed(drive));
                errors++;
            end
            else
            begin
                want = drive_q.pop_front();
                if (drive !== want)
                begin
                    $error("drive: expected %0d, got %0d", $signed(want), $signed(drive));
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int            cur_set;
        logic [31:0]   rd;
        logic [2:0]    r;
        pca_pkg::cfg_t c;
        logic [15:0]   aim;
        logic [15:0]   t;
        logic [15:0]   m;
        int            pick;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        target    = '0;
        measured  = '0;
        out_stall = 1'b0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        regs_now  = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, pca_pkg::DRIVE_HIGH_RESET};
        integ_sum = '0;
        last_meas = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = pca_pkg::REG_GAIN_PROP; r <= pca_pkg::REG_DRIVE_HIGH; r++)
        begin
            reg_read(r, rd);
            if (rd[15:0] !== regs_now[r])
            begin
                $error("%s: expected %0d, got %0d", reg_name[r], $signed(regs_now[r]),
                       $signed(rd[15:0]));
                errors++;
            end
        end

        cur_set = -1;
        foreach (plan[i])
        begin
            if (plan[i].set != cur_set)
            begin
                settle();
                cur_set = plan[i].set;
                apply_cfg(preset[cur_set]);
            end
            send(plan[i].tgt, plan[i].meas, plan[i].known, plan[i].drive);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            if (ph == 0)
                c = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000};
            else
                c = pick_cfg();
            apply_cfg(c);
            reg_write(REG_SPARE, 16'($urandom));
            calm = (ph == PHASES / 2);
            if (calm)
                hold_req = 1'b1;
            aim = 16'($urandom_range(0, 8000) - 4000);
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(0, 19) == 0)
                    aim = 16'($urandom_range(0, 8000) - 4000);
                pick = $urandom_range(0, 99);
                if (pick < 20)
                begin
                    t = 16'($urandom);
                    m = 16'($urandom);
                end
                else
                begin
                    t = aim;
                    m = 16'(aim + $urandom_range(0, 600) - 300);
                end
                send(t, m, 1'b0, '0);
            end
        end

        calm = 1'b0;
        settle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
